[rtl/egag_pkg.sv]
// Shared types and constants for the embedding gather address generator.
`timescale 1ns / 1ps

package egag_pkg;

  // Field widths
  localparam int ROW_IDX_W = 64;
  localparam int POS_W     = 16;
  localparam int ROWS_W    = 31;
  localparam int STRIDE_W  = 21;
  localparam int COFF_W    = 20;
  localparam int CCNT_W    = 7;
  localparam int SRC_W     = 52;
  localparam int DST_W     = 40;
  localparam int COL_W     = 6;
  localparam int CFG_W     = 31;
  localparam int CFG_IDX_W = 3;

  // Width used for all column window compares
  localparam int CMP_W     = 22;

  // Beats issued per index at most
  localparam int MAX_BEATS = 64;
  localparam int BEATS_W   = 7;

  // Queue between front and back
  localparam int QDEPTH    = 2;
  localparam int QPTR_W    = 1;
  localparam int QCNT_W    = 2;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROW_COUNT        = 3'd0,
    REG_ROW_STRIDE       = 3'd1,
    REG_COL_OFFSET       = 3'd2,
    REG_COL_COUNT        = 3'd3,
    REG_COL_LIMIT        = 3'd4,
    REG_DST_OUTER_STRIDE = 3'd5,
    REG_DST_INNER_STRIDE = 3'd6,
    REG_DST_COL_STRIDE   = 3'd7
  } reg_idx_t;

  // Configuration register set
  typedef struct packed {
    logic [ROWS_W-1:0]   row_count;
    logic [STRIDE_W-1:0] row_stride;
    logic [COFF_W-1:0]   col_offset;
    logic [CCNT_W-1:0]   col_count;
    logic [STRIDE_W-1:0] col_limit;
    logic [STRIDE_W-1:0] dst_outer_stride;
    logic [STRIDE_W-1:0] dst_inner_stride;
    logic [STRIDE_W-1:0] dst_col_stride;
  } cfg_t;

  // One classified index, ready for beat generation
  typedef struct packed {
    logic             drop;
    logic [SRC_W-1:0] src_base;
    logic [DST_W-1:0] dst_base;
  } entry_t;

  // One result beat
  typedef struct packed {
    logic [SRC_W-1:0] src_addr;
    logic [DST_W-1:0] dst_addr;
    logic [COL_W-1:0] column;
    logic             dropped;
    logic             last;
  } result_t;

endpackage

[rtl/egag_front.sv]
// Front end: accept an index, wrap and bound-check it, form source and destination bases.
`timescale 1ns / 1ps

module egag_front import egag_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  cfg_t                 cfg,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [ROW_IDX_W-1:0] row_index,
  input  logic [POS_W-1:0]     outer_pos,
  input  logic [POS_W-1:0]     inner_pos,
  output logic                 push,
  output entry_t               push_data,
  input  logic                 q_full
);

  typedef enum logic [1:0] {F_IDLE, F_WRAP, F_MUL, F_PUSH} fstate_t;

  localparam int PROD_W = POS_W + STRIDE_W;

  fstate_t              state;
  logic [ROW_IDX_W-1:0] idx;
  logic [POS_W-1:0]     outer;
  logic [POS_W-1:0]     inner;
  logic [ROWS_W-1:0]    row;
  logic                 drop;
  logic [PROD_W-1:0]    outer_prod;
  logic [PROD_W-1:0]    inner_prod;
  logic [SRC_W-1:0]     row_prod;
  logic [DST_W-1:0]     dst_base;
  logic [ROW_IDX_W-1:0] row_wrap;

  // Negative index counts from the end of the table
  always_comb begin
    if (idx[ROW_IDX_W-1]) begin
      row_wrap = idx + ROW_IDX_W'(cfg.row_count);
    end else begin
      row_wrap = idx;
    end
  end

  assign in_ready = (state == F_IDLE);
  assign push     = (state == F_PUSH) && !q_full;

  always_comb begin
    push_data.drop     = drop;
    push_data.src_base = row_prod + SRC_W'(cfg.col_offset);
    push_data.dst_base = dst_base;
  end

  // Step one index through wrap, multiply and hand-off
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      unique case (state)
        F_IDLE: begin
          if (in_valid) begin
            idx   <= row_index;
            outer <= outer_pos;
            inner <= inner_pos;
            state <= F_WRAP;
          end
        end
        F_WRAP: begin
          drop       <= row_wrap[ROW_IDX_W-1] ||
                        (row_wrap >= ROW_IDX_W'(cfg.row_count));
          row        <= row_wrap[ROWS_W-1:0];
          outer_prod <= PROD_W'(outer) * PROD_W'(cfg.dst_outer_stride);
          inner_prod <= PROD_W'(inner) * PROD_W'(cfg.dst_inner_stride);
          state      <= F_MUL;
        end
        F_MUL: begin
          row_prod <= SRC_W'(row) * SRC_W'(cfg.row_stride);
          dst_base <= DST_W'(outer_prod) + DST_W'(inner_prod);
          state    <= F_PUSH;
        end
        F_PUSH: begin
          if (!q_full) begin
            state <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

endmodule

[rtl/egag_queue.sv]
// Short queue of classified indexes between front and back.
`timescale 1ns / 1ps

module egag_queue import egag_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t push_data,
  output logic   full,
  input  logic   pop,
  output entry_t pop_data,
  output logic   not_empty
);

  entry_t              mem [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   count;

  assign full      = (count == QCNT_W'(QDEPTH));
  assign not_empty = (count != '0);
  assign pop_data  = mem[rd_ptr];

  // Store on push
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

[rtl/egag_back.sv]
// Back end: walk the column window and issue one address pair per cycle while the output is not stalled.
`timescale 1ns / 1ps

module egag_back import egag_pkg::*; #(
  parameter int MAX_COLS   = 64,
  parameter int BEAT_ELEMS = 1
) (
  input  logic    clk,
  input  logic    rst,
  input  cfg_t    cfg,
  input  logic    q_not_empty,
  input  entry_t  q_data,
  output logic    pop,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_res
);

  localparam int CW = $clog2(MAX_COLS + BEAT_ELEMS);

  typedef enum logic {B_IDLE, B_RUN} bstate_t;

  bstate_t          state;
  logic [CW-1:0]    col;
  logic [BEATS_W-1:0] beats;
  logic             drop;
  logic [SRC_W-1:0] src_base;
  logic [DST_W-1:0] dst_acc;
  logic [CW-1:0]    col_nx;
  logic [BEATS_W-1:0] beats_nx;
  logic [CMP_W-1:0] col_ext;
  logic             ok_cur;
  logic             ok_nx;
  logic             slot_free;
  logic [DST_W-1:0] dst_step;

  // True when a beat at this column is still inside the window and under the beat limit
  function automatic logic beat_ok(input cfg_t c, input logic [CW-1:0] cl,
                                   input logic [BEATS_W-1:0] nb);
    logic [CMP_W-1:0] ce;
    ce = CMP_W'(cl);
    return (ce < CMP_W'(c.col_count)) && (ce < CMP_W'(MAX_COLS)) &&
           ((CMP_W'(c.col_offset) + ce) < CMP_W'(c.col_limit)) &&
           (nb < BEATS_W'(MAX_BEATS));
  endfunction

  assign col_nx    = col + CW'(BEAT_ELEMS);
  assign beats_nx  = beats + 1'b1;
  assign col_ext   = CMP_W'(col);
  assign ok_cur    = beat_ok(cfg, col, beats);
  assign ok_nx     = beat_ok(cfg, col_nx, beats_nx);
  assign slot_free = !out_valid || out_ready;
  assign dst_step  = DST_W'(cfg.dst_col_stride) * DST_W'(BEAT_ELEMS);
  assign pop       = (state == B_IDLE) && q_not_empty;

  // Load an index, then issue its beats into the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      out_valid <= 1'b0;
    end else begin
      // Drop a taken transaction unless a new beat replaces it below
      if (out_ready && (state != B_RUN)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        B_IDLE: begin
          if (q_not_empty) begin
            col      <= '0;
            beats    <= '0;
            drop     <= q_data.drop;
            src_base <= q_data.src_base;
            dst_acc  <= q_data.dst_base;
            state    <= B_RUN;
          end
        end
        B_RUN: begin
          if (slot_free) begin
            out_valid <= 1'b1;
            if (drop || !ok_cur) begin
              out_res <= '{src_addr: '0, dst_addr: '0, column: '0,
                           dropped: 1'b1, last: 1'b1};
              state   <= B_IDLE;
            end else begin
              out_res.src_addr <= src_base + SRC_W'(col);
              out_res.dst_addr <= dst_acc;
              out_res.column   <= col_ext[COL_W-1:0];
              out_res.dropped  <= 1'b0;
              out_res.last     <= !ok_nx;
              col              <= col_nx;
              beats            <= beats_nx;
              dst_acc          <= dst_acc + dst_step;
              if (!ok_nx) begin
                state <= B_IDLE;
              end
            end
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

endmodule

[rtl/embedding_gather_address_generator.sv]
// The front steps each accepted index through its wrap, multiply and push states and
// takes no new index until it is idle again; the back loads an index and then issues
// one beat per cycle (up to 64) while the output is not stalled.
// A two-entry queue lets the front classify the next index while beats still issue.
// Reset (synchronous, active high) empties the queue, idles both ends, drops the
// output transaction and loads the configuration defaults.
`timescale 1ns / 1ps

module embedding_gather_address_generator import egag_pkg::*; #(
  parameter int MAX_COLS   = 64,
  parameter int BEAT_ELEMS = 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [95:0]          s_tdata,   // row_index[63:0], outer_pos[79:64], inner_pos[95:80]
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [103:0]         m_tdata,   // src_addr[51:0], dst_addr[91:52], column[97:92]
  output logic                 m_tuser,   // dropped
  output logic                 m_tlast
);

  cfg_t    cfg;
  logic    push;
  entry_t  push_data;
  logic    q_full;
  logic    pop;
  entry_t  pop_data;
  logic    q_not_empty;
  result_t res;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.row_count        <= ROWS_W'(1);
      cfg.row_stride       <= STRIDE_W'(64);
      cfg.col_offset       <= '0;
      cfg.col_count        <= CCNT_W'(64);
      cfg.col_limit        <= STRIDE_W'(64);
      cfg.dst_outer_stride <= '0;
      cfg.dst_inner_stride <= '0;
      cfg.dst_col_stride   <= STRIDE_W'(1);
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_ROW_COUNT:        cfg.row_count        <= cfg_data[ROWS_W-1:0];
        REG_ROW_STRIDE:       cfg.row_stride       <= cfg_data[STRIDE_W-1:0];
        REG_COL_OFFSET:       cfg.col_offset       <= cfg_data[COFF_W-1:0];
        REG_COL_COUNT:        cfg.col_count        <= cfg_data[CCNT_W-1:0];
        REG_COL_LIMIT:        cfg.col_limit        <= cfg_data[STRIDE_W-1:0];
        REG_DST_OUTER_STRIDE: cfg.dst_outer_stride <= cfg_data[STRIDE_W-1:0];
        REG_DST_INNER_STRIDE: cfg.dst_inner_stride <= cfg_data[STRIDE_W-1:0];
        REG_DST_COL_STRIDE:   cfg.dst_col_stride   <= cfg_data[STRIDE_W-1:0];
        default: ;
      endcase
    end
  end

  egag_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .row_index (s_tdata[63:0]),
    .outer_pos (s_tdata[79:64]),
    .inner_pos (s_tdata[95:80]),
    .push      (push),
    .push_data (push_data),
    .q_full    (q_full)
  );

  egag_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .pop_data  (pop_data),
    .not_empty (q_not_empty)
  );

  egag_back #(
    .MAX_COLS   (MAX_COLS),
    .BEAT_ELEMS (BEAT_ELEMS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .q_not_empty (q_not_empty),
    .q_data      (pop_data),
    .pop         (pop),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_res     (res)
  );

  // Pack the result transaction
  assign m_tdata = {6'b0, res.column, res.dst_addr, res.src_addr};
  assign m_tuser = res.dropped;
  assign m_tlast = res.last;

endmodule
